@@ rtl/utf8dw_pkg.sv @@
`timescale 1ns / 1ps

package utf8dw_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_CODE = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_CODE = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_CODE = 8'hf0;

  localparam logic [20:0] CP_SPACE  = 21'h000020;
  localparam logic [20:0] CP_HYPHEN = 21'h00002d;
  localparam logic [20:0] CP_SLASH  = 21'h00002f;
  localparam logic [20:0] CP_IDEO_COMMA = 21'h003001;
  localparam logic [20:0] CP_IDEO_STOP  = 21'h003002;
  localparam logic [20:0] CP_CJK_BASE   = 21'h002e80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        wrap_here;
    logic        end_of_string;
    logic        string_has_wrap;
  } out_item_t;

  // One decode job: up to four bytes, lead first, with byte count.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            fin;
  } job_t;

  function automatic logic [2:0] span_of(input logic [7:0] b);
    logic [2:0] s;
    if ((b & LEAD2_MASK) == LEAD2_CODE)      s = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) s = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) s = 3'd4;
    else                                     s = 3'd1;
    return s;
  endfunction

  function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] s);
    logic [20:0] v;
    unique case (s)
      3'd2:    v = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: v = {13'd0, b0};
    endcase
    return v;
  endfunction

  function automatic logic is_break(input logic [20:0] cp);
    return (cp == CP_SPACE) || (cp == CP_HYPHEN) || (cp == CP_SLASH) ||
           (cp == CP_IDEO_COMMA) || (cp == CP_IDEO_STOP) || (cp >= CP_CJK_BASE);
  endfunction

endpackage

@@ rtl/utf8dw_front.sv @@
`timescale 1ns / 1ps

module utf8dw_front import utf8dw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [7:0] pend_r [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] len_r, len_nxt;
  logic       acc;
  logic       push;
  logic       pend_we;
  logic [1:0] pend_idx;
  logic [2:0] span;
  logic [7:0] b;

  assign b        = in_data.data_byte;
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign span     = span_of(b);
  assign q_push   = acc && push;

  always_comb begin
    q_job.bytes[0] = (cnt_r == 2'd0) ? b : pend_r[0];
    q_job.bytes[1] = (cnt_r == 2'd1) ? b : ((cnt_r > 2'd1) ? pend_r[1] : 8'd0);
    q_job.bytes[2] = (cnt_r == 2'd2) ? b : ((cnt_r > 2'd2) ? pend_r[2] : 8'd0);
    q_job.bytes[3] = (cnt_r == 2'd3) ? b : 8'd0;
    q_job.n        = {1'b0, cnt_r} + 3'd1;
    q_job.fin      = in_data.is_final;
  end

  always_comb begin
    push     = 1'b0;
    pend_we  = 1'b0;
    pend_idx = cnt_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    if (in_data.is_final) begin
      push    = 1'b1;
      cnt_nxt = 2'd0;
      len_nxt = 3'd0;
    end else if (cnt_r == 2'd0) begin
      if (span == 3'd1) begin
        push = 1'b1;
      end else begin
        pend_we = 1'b1;
        cnt_nxt = 2'd1;
        len_nxt = span;
      end
    end else if (q_job.n >= len_r) begin
      // sequence complete
      push    = 1'b1;
      cnt_nxt = 2'd0;
      len_nxt = 3'd0;
    end else begin
      pend_we = 1'b1;
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      len_r <= 3'd0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pend_we) begin
      pend_r[pend_idx] <= b;
    end
  end

endmodule

@@ rtl/utf8dw_fifo.sv @@
`timescale 1ns / 1ps

module utf8dw_fifo import utf8dw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("fifo count over depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
`endif

endmodule

@@ rtl/utf8dw_back.sv @@
`timescale 1ns / 1ps

module utf8dw_back import utf8dw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0]  pos_r, pos_nxt;
  logic        wrap_seen_r, wrap_seen_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [7:0]  w0, w1, w2, w3;
  logic [2:0]  s;
  logic [3:0]  lead_end;
  logic [3:0]  k_next;
  logic        take_lead;
  logic [20:0] cp;
  logic        brk;
  logic        has;
  logic        last;
  logic        eos;
  logic        load;

  // byte window starting at the current position within the job
  always_comb begin
    case (pos_r)
      2'd0:    begin w0 = q_head.bytes[0]; w1 = q_head.bytes[1];
                     w2 = q_head.bytes[2]; w3 = q_head.bytes[3]; end
      2'd1:    begin w0 = q_head.bytes[1]; w1 = q_head.bytes[2];
                     w2 = q_head.bytes[3]; w3 = 8'd0; end
      2'd2:    begin w0 = q_head.bytes[2]; w1 = q_head.bytes[3];
                     w2 = 8'd0;            w3 = 8'd0; end
      default: begin w0 = q_head.bytes[3]; w1 = 8'd0;
                     w2 = 8'd0;            w3 = 8'd0; end
    endcase
  end

  always_comb begin
    s         = span_of(w0);
    lead_end  = {2'b00, pos_r} + {1'b0, s};
    take_lead = (s != 3'd1) && (lead_end <= {1'b0, q_head.n});
    cp        = take_lead ? assemble(w0, w1, w2, w3, s) : {13'd0, w0};
    k_next    = take_lead ? lead_end : ({2'b00, pos_r} + 4'd1);
    last      = (k_next >= {1'b0, q_head.n});
    eos       = last && q_head.fin;
    brk       = is_break(cp);
    has       = wrap_seen_r || brk;
    load      = !q_empty && (!out_valid_r || out_ready);
  end

  always_comb begin
    pos_nxt       = pos_r;
    wrap_seen_nxt = wrap_seen_r;
    if (load) begin
      pos_nxt       = last ? 2'd0 : k_next[1:0];
      wrap_seen_nxt = eos ? 1'b0 : has;
    end
  end

  assign q_pop     = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      wrap_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      wrap_seen_r <= wrap_seen_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.code_point      <= cp;
      out_item_r.wrap_here       <= brk;
      out_item_r.end_of_string   <= eos;
      out_item_r.string_has_wrap <= eos && has;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("job position out of range");
  a_has_wrap_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.string_has_wrap) |-> out_item_r.end_of_string)
    else $error("string_has_wrap without end_of_string");
  a_wrap_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (load && eos) |=> !wrap_seen_r)
    else $error("wrap flag kept past end of string");
`endif

endmodule

@@ rtl/utf8_decode_wrap_scan.sv @@
`timescale 1ns / 1ps

// Lenient streaming UTF-8 decoder with wrap-opportunity scan.
// Input channel (in_valid/in_ready/in_data): one text byte per item, with
// is_final marking the last byte of a string. Result channel
// (out_valid/out_ready/out_data): one code point per item, with its wrap
// flag; the last result of a string carries end_of_string and the
// string-wide wrap flag.
// A byte is taken every cycle while the job queue has room. Bytes that only
// extend an open sequence produce no result; a completing byte produces one,
// and a final byte one to three, sent one after another. A completed job is
// written to the job queue and its result is then registered in the back
// end. The back end emits one result per cycle while out_ready is high; the
// 4-entry job queue between front and back absorbs the extra results of a
// final byte and lets input continue while the receiver stalls.
// When out_ready is low the result holds; the queue fills and in_ready drops.
// Reset (synchronous, rst_n low) empties the queue, drops any open sequence
// and clears the wrap flag; the block is ready on the first cycle after.
module utf8_decode_wrap_scan import utf8dw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  utf8dw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  utf8dw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  utf8dw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/utf8dw_decode_check.sv @@
`timescale 1ns / 1ps

module utf8dw_decode_check import utf8dw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        miss_count,
  output int        pending_cnt
);

  // Decoder state as the block should hold it
  logic [7:0] held [3];
  int         held_cnt;
  int         seq_len;
  logic       string_wrap;
  out_item_t  code_point_q [$];

  function automatic int lead_span(input logic [7:0] b);
    casez (b)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic logic [20:0] join_bytes(input logic [7:0] seq [4], input int at,
                                             input int len);
    logic [31:0] v;
    int          i;
    case (len)
      2:       v = {27'd0, seq[at][4:0]};
      3:       v = {28'd0, seq[at][3:0]};
      4:       v = {29'd0, seq[at][2:0]};
      default: return {13'd0, seq[at]};
    endcase
    for (i = 1; i < len; i++) begin
      v = {v[25:0], seq[at + i][5:0]};
    end
    return v[20:0];
  endfunction

  function automatic logic breaks_line(input logic [20:0] cp);
    return (cp >= CP_CJK_BASE) ||
           (cp inside {CP_SPACE, CP_HYPHEN, CP_SLASH, CP_IDEO_COMMA, CP_IDEO_STOP});
  endfunction

  task automatic push_point(input logic [20:0] cp);
    out_item_t r;
    r.code_point      = cp;
    r.wrap_here       = breaks_line(cp);
    r.end_of_string   = 1'b0;
    r.string_has_wrap = 1'b0;
    if (r.wrap_here) begin
      string_wrap = 1'b1;
    end
    code_point_q = {code_point_q, r};
  endtask

  task automatic decode_byte(input in_item_t it);
    logic [7:0] seq [4];
    int         n;
    int         k;
    int         s;
    int         cnt;
    int         last;
    n = 0;
    for (k = 0; k < 4; k++) begin
      seq[k] = 8'h00;
    end
    for (k = 0; k < held_cnt; k++) begin
      seq[n] = held[k];
      n++;
    end
    seq[n] = it.data_byte;
    n++;
    if (!it.is_final) begin
      if (held_cnt == 0) begin
        s = lead_span(it.data_byte);
        if (s == 1) begin
          push_point({13'd0, it.data_byte});
        end else begin
          held[0]  = it.data_byte;
          held_cnt = 1;
          seq_len  = s;
        end
      end else if (n >= seq_len) begin
        push_point(join_bytes(seq, 0, seq_len));
        held_cnt = 0;
        seq_len  = 0;
      end else begin
        held[held_cnt] = it.data_byte;
        held_cnt++;
      end
    end else begin
      // end of string: re-scan everything held, leads lacking bytes go out raw
      k   = 0;
      cnt = 0;
      while (k < n && cnt < 3) begin
        s = lead_span(seq[k]);
        if (s > 1 && k + s <= n) begin
          push_point(join_bytes(seq, k, s));
          k += s;
        end else begin
          push_point({13'd0, seq[k]});
          k++;
        end
        cnt++;
      end
      last = code_point_q.size() - 1;
      code_point_q[last].end_of_string   = 1'b1;
      code_point_q[last].string_has_wrap = string_wrap;
      held_cnt    = 0;
      seq_len     = 0;
      string_wrap = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_cnt    = 0;
      seq_len     = 0;
      string_wrap = 1'b0;
      code_point_q.delete();
      miss_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (code_point_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("%0t: unexpected result cp=%h wrap=%b end=%b any=%b", $realtime,
                     out_data.code_point, out_data.wrap_here, out_data.end_of_string,
                     out_data.string_has_wrap);
          end
        end else begin
          want = code_point_q.pop_front();
          if (out_data.code_point !== want.code_point ||
              out_data.wrap_here !== want.wrap_here ||
              out_data.end_of_string !== want.end_of_string ||
              out_data.string_has_wrap !== want.string_has_wrap) begin
            miss_count++;
            if (miss_count <= 10) begin
              $display("%0t: result mismatch: expected cp=%h wrap=%b end=%b any=%b",
                       $realtime, want.code_point, want.wrap_here, want.end_of_string,
                       want.string_has_wrap);
              $display("%0t:                    got cp=%h wrap=%b end=%b any=%b",
                       $realtime, out_data.code_point, out_data.wrap_here,
                       out_data.end_of_string, out_data.string_has_wrap);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data);
      end
    end
    pending_cnt = code_point_q.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import utf8dw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // bit 8 marks the last byte of a string
  localparam logic [8:0] OPENING [25] = '{
    9'h000, 9'h020, 9'h02D, 9'h12F,          // ASCII NUL and wrap characters
    9'h1FF,                                  // stray high byte alone
    9'h0C3, 9'h0A9,                          // two-byte sequence
    9'h0E3, 9'h080, 9'h081,                  // ideographic comma
    9'h0E2, 9'h0B9, 9'h1BF,                  // just below the CJK range, completes on last
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,          // largest four-byte value
    9'h080, 9'h1C3,                          // stray continuation, lead as last byte
    9'h0F0, 9'h080, 9'h141,                  // string ends inside a sequence
    9'h0E3, 9'h080, 9'h182                   // ideographic full stop
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int         miss_count;
  int         pending_cnt;
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  logic       hold_armed = 1'b0;
  logic       hold_done  = 1'b0;
  int         hold_left  = 0;
  int         cycle_cnt  = 0;
  logic [7:0] text_q [$];

  utf8_decode_wrap_scan dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  utf8dw_decode_check u_decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .miss_count (miss_count),
    .pending_cnt(pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[utf8_decode_wrap_scan] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_left = 150;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, fin};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  function automatic logic [7:0] tail_byte();
    // continuation bits are masked off by the decoder, so junk is legal too
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom);
    end
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic build_string();
    int pts;
    int span;
    int j;
    text_q.delete();
    pts = $urandom_range(1, 6);
    repeat (pts) begin
      case ($urandom_range(0, 11))
        0, 1, 2: add_byte(8'($urandom_range(0, 127)));
        3: begin
          case ($urandom_range(0, 2))
            0:       add_byte(8'h20);
            1:       add_byte(8'h2D);
            default: add_byte(8'h2F);
          endcase
        end
        4: begin
          add_byte({3'b110, 5'($urandom)});
          add_byte(tail_byte());
        end
        5, 6: begin
          add_byte({4'b1110, 4'($urandom)});
          add_byte(tail_byte());
          add_byte(tail_byte());
        end
        7: begin
          case ($urandom_range(0, 3))
            0:       text_q = {text_q, 8'hE3, 8'h80, 8'h81};
            1:       text_q = {text_q, 8'hE3, 8'h80, 8'h82};
            2:       text_q = {text_q, 8'hE2, 8'hBA, 8'h80};
            default: text_q = {text_q, 8'hE2, 8'hB9, 8'hBF};
          endcase
        end
        8: begin
          add_byte({5'b11110, 3'($urandom)});
          repeat (3) add_byte(tail_byte());
        end
        9, 10: add_byte(8'($urandom));
        default: begin
          // truncated sequence
          span = $urandom_range(2, 4);
          case (span)
            2:       add_byte({3'b110, 5'($urandom)});
            3:       add_byte({4'b1110, 4'($urandom)});
            default: add_byte({5'b11110, 3'($urandom)});
          endcase
          j = $urandom_range(0, span - 2);
          repeat (j) add_byte(tail_byte());
        end
      endcase
    end
  endtask

  initial begin
    int k;
    int ph;
    int rand_bytes;
    rand_bytes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 25; k++) begin
      send_byte(OPENING[k][7:0], OPENING[k][8]);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 72;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 72;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      while (rand_bytes < (ph + 1) * 105) begin
        build_string();
        send_text();
        rand_bytes += text_q.size();
        if (ph == 0 && rand_bytes >= 40) begin
          hold_armed = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (miss_count == 0 && pending_cnt == 0) begin
      $display("[utf8_decode_wrap_scan] OK");
    end else begin
      $display("[utf8_decode_wrap_scan] ERROR");
    end
    $finish;
  end

endmodule
